@@ src/multichannel_conv2d_valid_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel convolution unit
// Shared helpers that wrap concurrent assertions with the clock and reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_CONV2D_VALID_UNIT_DEFINES_SVH
`define MULTICHANNEL_CONV2D_VALID_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mcv_pkg.sv @@
// ----------------------------------------------------------------------------
// mcv_pkg
// Shared widths, request and register codes, and pipeline flag type.
// ----------------------------------------------------------------------------
package mcv_pkg;

    localparam int DATA_WIDTH       = 16;
    localparam int FRAC_BITS        = DATA_WIDTH - 4;
    localparam int PROD_WIDTH       = 2 * DATA_WIDTH;
    localparam int ACC_WIDTH        = 40;
    localparam int REQ_WIDTH        = 2;
    localparam int WIDX_WIDTH       = 9;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH   = 7;
    localparam int IN_TDATA_WIDTH   = 32;

    localparam int DEF_MAX_WIDTH    = 64;
    localparam int DEF_MAX_KERNEL   = 5;
    localparam int DEF_MAX_CHANNELS = 16;

    localparam logic [REQ_WIDTH-1:0] REQ_WEIGHT = 2'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_BIAS   = 2'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_PIXEL  = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KERNEL_SIZE   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELU_ENABLE   = 3'd3;

    // Per-transaction flags carried down the pipeline.
    typedef struct packed {
        logic pixel;
        logic bias;
        logic do_out;
        logic first_ch;
        logic emit;
        logic last;
    } mcv_flags_t;

endpackage

@@ src/multichannel_conv2d_valid_unit.sv @@
// ----------------------------------------------------------------------------
// multichannel_conv2d_valid_unit
// One filter of a valid, stride-one K by K convolution over C channel images.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock cycle: weight loads, bias loads and
// pixels alike. A pixel's result is registered stage by stage up to the
// output register. The rate is set by the partial-sum memory, which is read and
// written once per pixel; the input stalls only while a result sits unclaimed
// in the output register and the next result is ready to take its place.
// Weights are held in one small memory per kernel tap so that all taps of a
// channel are read together. Line memories and the partial-sum memory need no
// clearing pass after reset. Configuration may be written only while idle;
// a geometry write restarts the image at row 0, column 0, channel 0.
`include "multichannel_conv2d_valid_unit_defines.svh"

module multichannel_conv2d_valid_unit #(
    parameter int MAX_WIDTH    = mcv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL   = mcv_pkg::DEF_MAX_KERNEL,
    parameter int MAX_CHANNELS = mcv_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // tdata: weight_index[8:0], data_value[24:9], zero fill [31:25]
    input  logic [mcv_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [mcv_pkg::REQ_WIDTH-1:0]         s_axis_tuser,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: result_value[15:0]
    output logic [mcv_pkg::DATA_WIDTH-1:0]        m_axis_tdata,
    output logic                                  m_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mcv_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [mcv_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int DW     = mcv_pkg::DATA_WIDTH;
    localparam int AW     = mcv_pkg::ACC_WIDTH;
    localparam int XW     = mcv_pkg::WIDX_WIDTH;
    localparam int KK     = MAX_KERNEL * MAX_KERNEL;
    localparam int LROWS  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PS_AW  = $clog2(MAX_WIDTH * MAX_WIDTH);

    // Configuration registers.
    logic [6:0]            image_width_reg;
    logic [2:0]            kernel_size_reg;
    logic [4:0]            channel_count_reg;
    logic                  relu_enable_reg;

    // Position counters.
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      row_reg;
    logic [CH_W-1:0]       ch_reg;
    logic [PS_AW-1:0]      pos_reg;

    int                    w_i;
    int                    k_i;
    int                    c_i;
    logic [COL_W-1:0]      w_last;
    logic [COL_W-1:0]      k_m1;
    logic [CH_W-1:0]       c_last;
    logic [KW-1:0]         k_eff;

    logic                  ce;
    logic                  busy;
    logic                  accept;
    logic [XW-1:0]         in_index;
    logic signed [DW-1:0]  in_data;
    logic                  is_pixel;
    logic                  do_out;
    mcv_pkg::mcv_flags_t   in_flags;

    logic                  st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg;
    mcv_pkg::mcv_flags_t   st1_flags_reg, st2_flags_reg, st3_flags_reg, st4_flags_reg;
    logic [PS_AW-1:0]      st1_pos_reg, st2_pos_reg, st3_pos_reg, st4_pos_reg;
    logic signed [DW-1:0]  st1_data_reg, st2_data_reg, st3_data_reg, st4_data_reg;
    logic [COL_W-1:0]      st1_col_reg;

    logic signed [DW-1:0]  weights  [KK];
    logic signed [DW-1:0]  col_data [LROWS];
    logic signed [AW-1:0]  total;

    // Effective geometry after clamping.
    always_comb
    begin
        w_i = int'(image_width_reg);
        if (w_i < 2) w_i = 2;
        if (w_i > MAX_WIDTH) w_i = MAX_WIDTH;
        k_i = int'(kernel_size_reg);
        if (k_i < 1) k_i = 1;
        if (k_i > MAX_KERNEL) k_i = MAX_KERNEL;
        if (k_i > w_i) k_i = w_i;
        c_i = int'(channel_count_reg);
        if (c_i < 1) c_i = 1;
        if (c_i > MAX_CHANNELS) c_i = MAX_CHANNELS;
        w_last = COL_W'(w_i - 1);
        k_m1   = COL_W'(k_i - 1);
        c_last = CH_W'(c_i - 1);
        k_eff  = KW'(k_i);
    end

    assign ce            = !busy;
    assign s_axis_tready = ce;
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && ce;
    assign in_index      = s_axis_tdata[XW-1:0];
    assign in_data       = s_axis_tdata[XW+DW-1:XW];
    assign is_pixel      = s_axis_tuser == mcv_pkg::REQ_PIXEL;
    assign do_out        = (row_reg >= k_m1) && (col_reg >= k_m1);

    always_comb
    begin
        in_flags.pixel    = is_pixel;
        in_flags.bias     = s_axis_tuser == mcv_pkg::REQ_BIAS;
        in_flags.do_out   = is_pixel && do_out;
        in_flags.first_ch = ch_reg == '0;
        in_flags.emit     = is_pixel && do_out && (ch_reg == c_last);
        in_flags.last     = (row_reg == w_last) && (col_reg == w_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 7'd32;
            kernel_size_reg   <= 3'd3;
            channel_count_reg <= 5'd1;
            relu_enable_reg   <= 1'b0;
            col_reg           <= '0;
            row_reg           <= '0;
            ch_reg            <= '0;
            pos_reg           <= '0;
            st1_valid_reg     <= 1'b0;
            st2_valid_reg     <= 1'b0;
            st3_valid_reg     <= 1'b0;
            st4_valid_reg     <= 1'b0;
            st1_flags_reg     <= '0;
            st2_flags_reg     <= '0;
            st3_flags_reg     <= '0;
            st4_flags_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    mcv_pkg::REG_IMAGE_WIDTH:
                    begin
                        image_width_reg <= cfg_data;
                        col_reg <= '0; row_reg <= '0; ch_reg <= '0; pos_reg <= '0;
                    end
                    mcv_pkg::REG_KERNEL_SIZE:
                    begin
                        kernel_size_reg <= cfg_data[2:0];
                        col_reg <= '0; row_reg <= '0; ch_reg <= '0; pos_reg <= '0;
                    end
                    mcv_pkg::REG_CHANNEL_COUNT:
                    begin
                        channel_count_reg <= cfg_data[4:0];
                        col_reg <= '0; row_reg <= '0; ch_reg <= '0; pos_reg <= '0;
                    end
                    mcv_pkg::REG_RELU_ENABLE:
                    begin
                        relu_enable_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (accept && is_pixel)
            begin
                if (do_out)
                begin
                    pos_reg <= pos_reg + PS_AW'(1);
                end
                if (col_reg == w_last)
                begin
                    col_reg <= '0;
                    if (row_reg == w_last)
                    begin
                        row_reg <= '0;
                        pos_reg <= '0;
                        ch_reg  <= (ch_reg == c_last) ? '0 : ch_reg + CH_W'(1);
                    end
                    else
                    begin
                        row_reg <= row_reg + COL_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (ce)
            begin
                st1_valid_reg <= s_axis_tvalid;
                st2_valid_reg <= st1_valid_reg;
                st3_valid_reg <= st2_valid_reg;
                st4_valid_reg <= st3_valid_reg;
                st1_flags_reg <= s_axis_tvalid ? in_flags : '0;
                st2_flags_reg <= st1_flags_reg;
                st3_flags_reg <= st2_flags_reg;
                st4_flags_reg <= st3_flags_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            st1_pos_reg  <= pos_reg;
            st2_pos_reg  <= st1_pos_reg;
            st3_pos_reg  <= st2_pos_reg;
            st4_pos_reg  <= st3_pos_reg;
            st1_data_reg <= in_data;
            st2_data_reg <= st1_data_reg;
            st3_data_reg <= st2_data_reg;
            st4_data_reg <= st3_data_reg;
            st1_col_reg  <= col_reg;
        end
    end

    mcv_weight_mem #(
        .MAX_KERNEL   (MAX_KERNEL),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_weight_mem (
        .clk      (clk),
        .ce       (ce),
        .wr_en    (accept && (s_axis_tuser == mcv_pkg::REQ_WEIGHT)),
        .wr_index (in_index),
        .wr_data  (in_data),
        .rd_chan  (ch_reg),
        .rd_lane  (weights)
    );

    mcv_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .rd_col   (col_reg),
        .wr_en    (ce && st1_valid_reg && st1_flags_reg.pixel),
        .wr_col   (st1_col_reg),
        .k        (k_eff),
        .wr_pixel (st1_data_reg),
        .col_data (col_data)
    );

    mcv_window_mac #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_window_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .step     (ce && st1_valid_reg && st1_flags_reg.pixel),
        .k        (k_eff),
        .col_data (col_data),
        .pixel    (st1_data_reg),
        .weights  (weights),
        .total    (total)
    );

    mcv_accum #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .relu      (relu_enable_reg),
        .rd_pos    (st3_pos_reg),
        .st4_valid (st4_valid_reg),
        .st4_flags (st4_flags_reg),
        .st4_pos   (st4_pos_reg),
        .st4_data  (st4_data_reg),
        .total     (total),
        .busy      (busy),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_last    (m_axis_tlast)
    );

    // A position read for accumulation is never the one being written back.
    `MCV_ASSERT_SAME(a_ps_no_overlap, clk, rst_n, ce && st4_valid_reg && st4_flags_reg.do_out && st3_valid_reg && st3_flags_reg.do_out && !st3_flags_reg.first_ch, st3_pos_reg != st4_pos_reg, "partial sum read overlaps write back")

    // The input side stalls only behind an unclaimed result.
    `MCV_ASSERT_SAME(a_stall_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a pending result")

    // A stalled result stays presented in the next cycle.
    `MCV_ASSERT_NEXT(a_result_kept, clk, rst_n, busy, m_axis_tvalid, "pending result dropped during stall")

endmodule

@@ src/mcv_weight_mem.sv @@
// ----------------------------------------------------------------------------
// mcv_weight_mem
// Kernel weight storage, one memory lane per kernel tap, addressed by channel.
// ----------------------------------------------------------------------------
module mcv_weight_mem #(
    parameter int MAX_KERNEL   = mcv_pkg::DEF_MAX_KERNEL,
    parameter int MAX_CHANNELS = mcv_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                   clk,
    input  logic                                   ce,
    input  logic                                   wr_en,
    input  logic [mcv_pkg::WIDX_WIDTH-1:0]         wr_index,
    input  logic signed [mcv_pkg::DATA_WIDTH-1:0]  wr_data,
    input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_chan,
    output logic signed [mcv_pkg::DATA_WIDTH-1:0]  rd_lane [MAX_KERNEL*MAX_KERNEL]
);

    localparam int DW     = mcv_pkg::DATA_WIDTH;
    localparam int XW     = mcv_pkg::WIDX_WIDTH;
    localparam int KK     = MAX_KERNEL * MAX_KERNEL;
    localparam int SLOTS  = KK * MAX_CHANNELS;
    localparam int LANE_W = (KK > 1) ? $clog2(KK) : 1;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RSHIFT = 20;
    localparam int RECIP  = (1 << RSHIFT) / KK;
    localparam int PW     = XW + RSHIFT + 1;

    logic signed [DW-1:0] mem [KK][MAX_CHANNELS];
    logic [PW-1:0]        recip_prod;
    logic [XW-1:0]        quo_est;
    logic [XW-1:0]        rem_est;
    logic [XW-1:0]        quo;
    logic [XW-1:0]        rem;
    logic                 in_range;
    logic [LANE_W-1:0]    wr_lane;
    logic [CH_W-1:0]      wr_chan;

    // Slot split by multiplying with the reciprocal of the taps per channel;
    // the estimate is at most one low, so a single correction step fixes it.
    always_comb
    begin
        recip_prod = PW'(wr_index) * PW'(RECIP);
        quo_est    = recip_prod[XW+RSHIFT-1:RSHIFT];
        rem_est    = wr_index - XW'(quo_est * XW'(KK));
        if (rem_est >= XW'(KK))
        begin
            quo = quo_est + XW'(1);
            rem = rem_est - XW'(KK);
        end
        else
        begin
            quo = quo_est;
            rem = rem_est;
        end
        in_range = int'(wr_index) < SLOTS;
        wr_lane  = LANE_W'(rem);
        wr_chan  = CH_W'(quo);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && in_range)
        begin
            mem[wr_lane][wr_chan] <= wr_data;
        end
        if (ce)
        begin
            for (int l = 0; l < KK; l++)
            begin
                rd_lane[l] <= mem[l][rd_chan];
            end
        end
    end

endmodule

@@ src/mcv_line_buf.sv @@
// ----------------------------------------------------------------------------
// mcv_line_buf
// Line memories holding the previous K-1 image rows, one memory per row.
// ----------------------------------------------------------------------------
module mcv_line_buf #(
    parameter int MAX_WIDTH  = mcv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = mcv_pkg::DEF_MAX_KERNEL
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   ce,
    input  logic [$clog2(MAX_WIDTH)-1:0]           rd_col,
    input  logic                                   wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]           wr_col,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]        k,
    input  logic signed [mcv_pkg::DATA_WIDTH-1:0]  wr_pixel,
    output logic signed [mcv_pkg::DATA_WIDTH-1:0]
        col_data [(MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1]
);

    localparam int DW    = mcv_pkg::DATA_WIDTH;
    localparam int LROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

    logic signed [DW-1:0]  mem [LROWS][MAX_WIDTH];
    logic signed [DW-1:0]  rd_reg [LROWS];
    logic [LROWS-1:0]      rd_vld_reg;
    logic [MAX_WIDTH-1:0]  vld_reg [LROWS];
    logic signed [DW-1:0]  wr_row_data [LROWS];
    logic [LROWS-1:0]      wr_row_en;

    genvar r;
    generate
        for (r = 0; r < LROWS; r++)
        begin : g_row
            // A never written entry reads as zero.
            assign col_data[r]  = rd_vld_reg[r] ? rd_reg[r] : '0;
            // Rows below K-2 shift up by one; row K-2 takes the new pixel.
            assign wr_row_en[r] = wr_en && ((r + 2) <= int'(k));
            if (r + 1 < LROWS)
            begin : g_shift
                assign wr_row_data[r] = ((r + 2) == int'(k)) ? wr_pixel : col_data[r+1];
            end
            else
            begin : g_top
                assign wr_row_data[r] = wr_pixel;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LROWS; i++)
        begin
            if (wr_row_en[i])
            begin
                mem[i][wr_col] <= wr_row_data[i];
            end
            if (ce)
            begin
                rd_reg[i] <= mem[i][rd_col];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= '0;
            for (int i = 0; i < LROWS; i++)
            begin
                vld_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < LROWS; i++)
            begin
                if (wr_row_en[i])
                begin
                    vld_reg[i][wr_col] <= 1'b1;
                end
                if (ce)
                begin
                    rd_vld_reg[i] <= vld_reg[i][rd_col];
                end
            end
        end
    end

endmodule

@@ src/mcv_window_mac.sv @@
// ----------------------------------------------------------------------------
// mcv_window_mac
// K by K window registers, tap multipliers and a registered adder tree.
// ----------------------------------------------------------------------------
module mcv_window_mac #(
    parameter int MAX_KERNEL = mcv_pkg::DEF_MAX_KERNEL
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   ce,
    input  logic                                   step,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]        k,
    input  logic signed [mcv_pkg::DATA_WIDTH-1:0]
        col_data [(MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1],
    input  logic signed [mcv_pkg::DATA_WIDTH-1:0]  pixel,
    input  logic signed [mcv_pkg::DATA_WIDTH-1:0]  weights [MAX_KERNEL*MAX_KERNEL],
    output logic signed [mcv_pkg::ACC_WIDTH-1:0]   total
);

    localparam int DW     = mcv_pkg::DATA_WIDTH;
    localparam int PW     = mcv_pkg::PROD_WIDTH;
    localparam int AW     = mcv_pkg::ACC_WIDTH;
    localparam int MK     = MAX_KERNEL;
    localparam int KK     = MK * MK;
    localparam int LROWS  = (MK > 1) ? MK - 1 : 1;
    localparam int LANE_W = (KK > 1) ? $clog2(KK) : 1;

    logic signed [DW-1:0] win_reg  [MK][MK];
    logic signed [DW-1:0] win_next [MK][MK];
    logic signed [DW-1:0] wsel     [MK][MK];
    logic [MK-1:0]        tap_en   [MK];
    logic signed [DW-1:0] colv     [MK];
    logic signed [PW-1:0] prod_reg [MK][MK];
    logic signed [AW-1:0] row_sum  [MK];
    logic signed [AW-1:0] row_reg  [MK];
    logic signed [AW-1:0] tot_sum;
    logic signed [AW-1:0] total_reg;

    genvar r, s;
    generate
        for (r = 0; r < MK; r++)
        begin : g_r
            if (r < LROWS)
            begin : g_line
                assign colv[r] = ((r + 1) == int'(k)) ? pixel : col_data[r];
            end
            else
            begin : g_new
                assign colv[r] = pixel;
            end
            for (s = 0; s < MK; s++)
            begin : g_s
                logic [LANE_W-1:0] lane;
                assign tap_en[r][s] = (r < int'(k)) && (s < int'(k));
                assign lane = tap_en[r][s] ?
                    (LANE_W'(r) * LANE_W'(k) + LANE_W'(s)) : '0;
                assign wsel[r][s] = weights[lane];
                if (s + 1 < MK)
                begin : g_shift
                    assign win_next[r][s] = !(r < int'(k)) ? win_reg[r][s] :
                        ((s + 1) < int'(k)) ? win_reg[r][s+1] :
                        ((s + 1) == int'(k)) ? colv[r] : win_reg[r][s];
                end
                else
                begin : g_edge
                    assign win_next[r][s] = ((r < int'(k)) && ((s + 1) == int'(k))) ?
                        colv[r] : win_reg[r][s];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MK; i++)
            begin
                for (int j = 0; j < MK; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (step)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        tot_sum = '0;
        for (int i = 0; i < MK; i++)
        begin
            row_sum[i] = '0;
            for (int j = 0; j < MK; j++)
            begin
                row_sum[i] = row_sum[i] + AW'(prod_reg[i][j]);
            end
            tot_sum = tot_sum + row_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < MK; i++)
            begin
                for (int j = 0; j < MK; j++)
                begin
                    // Both arms signed so the product is a signed multiply.
                    prod_reg[i][j] <= tap_en[i][j] ? (win_next[i][j] * wsel[i][j]) :
                        $signed(PW'(0));
                end
                row_reg[i] <= row_sum[i];
            end
            total_reg <= tot_sum;
        end
    end

    assign total = total_reg;

endmodule

@@ src/mcv_accum.sv @@
// ----------------------------------------------------------------------------
// mcv_accum
// Partial-sum memory with read-modify-write, bias, rounding and output stage.
// ----------------------------------------------------------------------------
module mcv_accum #(
    parameter int MAX_WIDTH = mcv_pkg::DEF_MAX_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   ce,
    input  logic                                   relu,
    input  logic [$clog2(MAX_WIDTH*MAX_WIDTH)-1:0] rd_pos,
    input  logic                                   st4_valid,
    input  mcv_pkg::mcv_flags_t                    st4_flags,
    input  logic [$clog2(MAX_WIDTH*MAX_WIDTH)-1:0] st4_pos,
    input  logic signed [mcv_pkg::DATA_WIDTH-1:0]  st4_data,
    input  logic signed [mcv_pkg::ACC_WIDTH-1:0]   total,
    output logic                                   busy,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [mcv_pkg::DATA_WIDTH-1:0]         m_data,
    output logic                                   m_last
);

    localparam int DW       = mcv_pkg::DATA_WIDTH;
    localparam int AW       = mcv_pkg::ACC_WIDTH;
    localparam int FB       = mcv_pkg::FRAC_BITS;
    localparam int PS_DEPTH = MAX_WIDTH * MAX_WIDTH;
    localparam int SW       = AW - FB + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'(2 ** (DW - 1) - 1);
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    logic signed [AW-1:0] ps_mem [PS_DEPTH];
    logic signed [AW-1:0] ps_rd_reg;
    logic signed [AW-1:0] acc_sum;

    logic                 st5_valid_reg;
    mcv_pkg::mcv_flags_t  st5_flags_reg;
    logic signed [AW-1:0] st5_acc_reg;
    logic signed [DW-1:0] st5_data_reg;
    logic signed [DW-1:0] bias_reg;

    logic signed [AW-1:0] biased;
    logic signed [AW:0]   rounded;
    logic signed [SW-1:0] shifted;
    logic signed [SW-1:0] clipped;
    logic [DW-1:0]        result;

    logic                 m_valid_reg;
    logic [DW-1:0]        m_data_reg;
    logic                 m_last_reg;

    // The first channel overwrites a position; later channels add to it.
    assign acc_sum = total + (st4_flags.first_ch ? AW'(0) : ps_rd_reg);

    always_ff @(posedge clk)
    begin
        if (ce && st4_valid && st4_flags.do_out)
        begin
            ps_mem[st4_pos] <= acc_sum;
        end
        if (ce)
        begin
            ps_rd_reg    <= ps_mem[rd_pos];
            st5_acc_reg  <= acc_sum;
            st5_data_reg <= st4_data;
        end
        if (ce && st5_valid_reg && st5_flags_reg.emit)
        begin
            m_data_reg <= result;
            m_last_reg <= st5_flags_reg.last;
        end
    end

    always_comb
    begin
        biased  = st5_acc_reg + (AW'(bias_reg) <<< FB);
        rounded = (AW + 1)'(biased) + (AW + 1)'(2 ** (FB - 1));
        shifted = SW'(rounded >>> FB);
        clipped = (relu && (shifted < 0)) ? '0 : shifted;
        if (clipped > SAT_HI)
        begin
            result = DW'(SAT_HI);
        end
        else if (clipped < SAT_LO)
        begin
            result = DW'(SAT_LO);
        end
        else
        begin
            result = DW'(clipped);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st5_valid_reg <= 1'b0;
            st5_flags_reg <= '0;
            bias_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ce)
            begin
                st5_valid_reg <= st4_valid;
                st5_flags_reg <= st4_flags;
                if (st5_valid_reg && st5_flags_reg.bias)
                begin
                    bias_reg <= st5_data_reg;
                end
            end
            if (ce && st5_valid_reg && st5_flags_reg.emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign busy    = st5_valid_reg && st5_flags_reg.emit && m_valid_reg && !m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for multichannel_conv2d_valid_unit
// Loads weights and bias, then streams channel images through the unit under
// many geometry settings. Each output is checked against a predictor that
// keeps its own line buffers, window and partial sums. Both stream sides
// stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 16;
    localparam logic [mcv_pkg::REQ_WIDTH-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } conv_out_t;

    logic                                clk;
    logic                                rst_n;
    logic [mcv_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata;
    logic [mcv_pkg::REQ_WIDTH-1:0]       s_axis_tuser;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [mcv_pkg::DATA_WIDTH-1:0]      m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [mcv_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [mcv_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    // Shadow copy of the unit's configuration and datapath state.
    logic [6:0]           img_w_reg;
    logic [2:0]           kern_reg;
    logic [4:0]           chan_reg;
    logic                 relu_reg;
    logic signed [15:0]   weights [400];
    logic signed [15:0]   bias;
    logic signed [15:0]   line_mem [256];
    logic signed [15:0]   window [25];
    logic [39:0]          psums [4096];
    int                   cur_col, cur_row, cur_ch;

    conv_out_t conv_out_q[$];
    int        mismatch_count;
    int        error_count;
    int        idle_cycles;
    int        rx_hold;
    int        items_sent;
    bit        idling_on;

    multichannel_conv2d_valid_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int eff_width();
        return clamp_int(img_w_reg, 2, mcv_pkg::DEF_MAX_WIDTH);
    endfunction

    function automatic int eff_kernel();
        int k;
        k = clamp_int(kern_reg, 1, mcv_pkg::DEF_MAX_KERNEL);
        return (k > eff_width()) ? eff_width() : k;
    endfunction

    function automatic int eff_channels();
        return clamp_int(chan_reg, 1, mcv_pkg::DEF_MAX_CHANNELS);
    endfunction

    task automatic reset_shadow();
        img_w_reg = 7'd32;
        kern_reg  = 3'd3;
        chan_reg  = 5'd1;
        relu_reg  = 1'b0;
        bias      = '0;
        foreach (weights[i]) weights[i] = '0;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (window[i]) window[i] = '0;
        foreach (psums[i]) psums[i] = '0;
        cur_col = 0;
        cur_row = 0;
        cur_ch  = 0;
    endtask

    // One pixel through the line buffers, window and accumulator.
    task automatic compute_conv_output(logic signed [15:0] pix);
        int                 w, k, c, pos;
        logic signed [15:0] colv [5];
        logic [63:0]        acc;
        logic [39:0]        tot;
        longint             v;
        conv_out_t          res;
        w = eff_width();
        k = eff_kernel();
        c = eff_channels();
        for (int r = 0; r + 1 < k; r++)
            colv[r] = line_mem[r * 64 + cur_col];
        colv[k - 1] = pix;
        for (int r = 0; r + 2 < k; r++)
            line_mem[r * 64 + cur_col] = line_mem[(r + 1) * 64 + cur_col];
        if (k >= 2)
            line_mem[(k - 2) * 64 + cur_col] = pix;
        for (int r = 0; r < k; r++)
        begin
            for (int s = 0; s + 1 < k; s++)
                window[r * 5 + s] = window[r * 5 + s + 1];
            window[r * 5 + k - 1] = colv[r];
        end
        if (cur_row + 1 >= k && cur_col + 1 >= k)
        begin
            pos = (cur_row - (k - 1)) * (w - k + 1) + (cur_col - (k - 1));
            acc = '0;
            for (int r = 0; r < k; r++)
                for (int s = 0; s < k; s++)
                    acc += 64'(longint'(window[r * 5 + s]) *
                               longint'(weights[cur_ch * 25 + r * k + s]));
            if (cur_ch != 0)
                acc += {24'd0, psums[pos]};
            psums[pos] = acc[39:0];
            if (cur_ch + 1 == c)
            begin
                tot = acc[39:0] + 40'({{24{bias[15]}}, bias} << mcv_pkg::FRAC_BITS);
                v = (longint'($signed(tot)) + 2048) >>> mcv_pkg::FRAC_BITS;
                if (relu_reg && v < 0)
                    v = 0;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                res.value = v[15:0];
                res.last  = (cur_row + 1 == w) && (cur_col + 1 == w);
                conv_out_q.push_back(res);
            end
        end
        cur_col++;
        if (cur_col >= w)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= w)
            begin
                cur_row = 0;
                cur_ch++;
                if (cur_ch >= c)
                    cur_ch = 0;
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [1:0] req, logic [8:0] widx, logic [15:0] value);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tdata  = {7'd0, value, widx};
        s_axis_tuser  = req;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        case (req)
            mcv_pkg::REQ_WEIGHT: if (widx < 400) weights[widx] = value;
            mcv_pkg::REQ_BIAS:   bias = value;
            mcv_pkg::REQ_PIXEL:  compute_conv_output(value);
            default:             ;
        endcase
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid = 1'b0;
        while (conv_out_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [6:0] value);
        wait_drain();
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mcv_pkg::REG_IMAGE_WIDTH:   img_w_reg = value;
            mcv_pkg::REG_KERNEL_SIZE:   kern_reg = value[2:0];
            mcv_pkg::REG_CHANNEL_COUNT: chan_reg = value[4:0];
            mcv_pkg::REG_RELU_ENABLE:   relu_reg = value[0];
            default:                    ;
        endcase
        if (idx <= mcv_pkg::REG_CHANNEL_COUNT)
        begin
            cur_col = 0;
            cur_row = 0;
            cur_ch  = 0;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(int w, int k, int c, int relu);
        write_reg(mcv_pkg::REG_IMAGE_WIDTH, 7'(w));
        write_reg(mcv_pkg::REG_KERNEL_SIZE, 7'(k));
        write_reg(mcv_pkg::REG_CHANNEL_COUNT, 7'(c));
        write_reg(mcv_pkg::REG_RELU_ENABLE, 7'(relu));
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'(int'($urandom_range(0, 8191)) - 4096);
            default: return 16'($urandom());
        endcase
    endfunction

    // Every weight slot that the current geometry reads, plus the bias.
    task automatic load_filter();
        int k;
        k = eff_kernel();
        for (int ch = 0; ch < eff_channels(); ch++)
            for (int t = 0; t < k * k; t++)
                send_item(mcv_pkg::REQ_WEIGHT, 9'(ch * 25 + t), rand_value());
        send_item(mcv_pkg::REQ_BIAS, 9'($urandom()), rand_value());
    endtask

    task automatic send_images(int count, int noise_pct);
        int n;
        n = count * eff_channels() * eff_width() * eff_width();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                case ($urandom_range(0, 2))
                    0: send_item(REQ_UNUSED, 9'($urandom()), 16'($urandom()));
                    1: send_item(mcv_pkg::REQ_WEIGHT, 9'($urandom_range(400, 511)),
                                 rand_value());
                    default: send_item(mcv_pkg::REQ_BIAS, 9'($urandom()), rand_value());
                endcase
            end
            send_item(mcv_pkg::REQ_PIXEL, 9'($urandom()), rand_value());
        end
    endtask

    task automatic test_directed();
        configure(4, 3, 1, 0);
        for (int t = 0; t < 9; t++)
            send_item(mcv_pkg::REQ_WEIGHT, 9'(t), (t % 2) ? 16'h8000 : 16'h7FFF);
        send_item(mcv_pkg::REQ_BIAS, 9'h1FF, 16'h8000);
        send_item(REQ_UNUSED, 9'h1FF, 16'hFFFF);
        send_item(mcv_pkg::REQ_WEIGHT, 9'h1FF, 16'h1234);
        for (int i = 0; i < 16; i++)
            send_item(mcv_pkg::REQ_PIXEL, 9'd0, (i % 3 == 0) ? 16'h8000 : 16'h7FFF);
        write_reg(mcv_pkg::REG_RELU_ENABLE, 7'd1);
        send_images(1, 0);
        // Unknown register indexes must leave everything alone.
        write_reg(3'd4, 7'h7F);
        write_reg(3'd7, 7'h55);
        send_images(1, 0);
    endtask

    task automatic test_geometry_extremes();
        configure(2, 1, 1, 0);
        load_filter();
        send_images(1, 0);
        configure(3, 2, 3, 1);
        load_filter();
        send_images(1, 0);
        configure(5, 5, 1, 0);
        load_filter();
        send_images(1, 0);
        // Out-of-range register values are clamped by the unit.
        configure(0, 7, 31, 1);
        load_filter();
        send_images(1, 0);
        // Widest image, one output per pixel; the image is cut short.
        configure(127, 0, 0, 0);
        load_filter();
        for (int i = 0; i < 80; i++)
            send_item(mcv_pkg::REQ_PIXEL, 9'($urandom()), rand_value());
    endtask

    task automatic test_random_layers();
        int start;
        start = items_sent;
        while (items_sent - start < 100)
        begin
            configure($urandom_range(2, 6), $urandom_range(0, 7), $urandom_range(1, 3),
                      $urandom_range(0, 1));
            load_filter();
            send_images(1, 5);
            // A partial image that a geometry write cuts short.
            if ($urandom_range(0, 3) == 0)
                for (int i = 0; i < $urandom_range(1, 10); i++)
                    send_item(mcv_pkg::REQ_PIXEL, 9'($urandom()), rand_value());
        end
    endtask

    task automatic test_backpressure();
        configure(6, 3, 2, 0);
        load_filter();
        rx_hold = 120;
        send_images(1, 0);
        wait_drain();
        send_images(1, 0);
    endtask

    task automatic test_full_rate();
        idling_on = 1'b0;
        configure(5, 4, 2, 1);
        load_filter();
        send_images(2, 0);
    endtask

    // Receiver: random short stalls, and one long hold when requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready = 1'b0;
                rx_hold--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        conv_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (conv_out_q.size() == 0)
            begin
                error_count++;
                if (mismatch_count < 10)
                    $display("unexpected result value=%h last=%b", m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end
            else
            begin
                want = conv_out_q.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tlast !== want.last)
                begin
                    error_count++;
                    if (mismatch_count < 10)
                        $display("mismatch: expected value=%h last=%b, got value=%h last=%b",
                                 want.value, want.last, m_axis_tdata, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("multichannel_conv2d_valid_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        s_axis_tvalid  = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        error_count    = 0;
        idle_cycles    = 0;
        rx_hold        = 0;
        items_sent     = 0;
        idling_on      = 1'b1;
        reset_shadow();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_geometry_extremes();
        test_random_layers();
        test_backpressure();
        test_full_rate();

        wait_drain();
        error_count += conv_out_q.size();
        if (error_count == 0)
            $display("multichannel_conv2d_valid_unit verification clean");
        else
            $display("multichannel_conv2d_valid_unit verification failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/mcv_pkg.sv
src/mcv_weight_mem.sv
src/mcv_line_buf.sv
src/mcv_window_mac.sv
src/mcv_accum.sv
src/multichannel_conv2d_valid_unit.sv
tb/sv/testbench.sv
